// ===== src/msrpb_pkg.sv =====
// Package for the MSR permission bitmap.
// Holds map size default, action codes, range prefixes and byte bases.
// Used by msr_permission_bitmap.
package msrpb_pkg;

  localparam int MAP_BYTES_DEF = 8192;
  localparam int BYTE_W        = 8;
  localparam int OFF_W         = 13;
  localparam int PREFIX_W      = 19;

  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_TEST  = 2'd2;

  localparam logic [PREFIX_W-1:0] PREFIX_LOW  = 19'h00000;
  localparam logic [PREFIX_W-1:0] PREFIX_HIGH = 19'h60000;
  localparam logic [PREFIX_W-1:0] PREFIX_EXT  = 19'h60008;

  localparam logic [OFF_W-1:0] BASE_LOW  = 13'h0000;
  localparam logic [OFF_W-1:0] BASE_HIGH = 13'h0800;
  localparam logic [OFF_W-1:0] BASE_EXT  = 13'h1000;

  localparam logic [BYTE_W-1:0] ALL_INTERCEPT = 8'hff;

endpackage

// ===== src/msr_permission_bitmap.sv =====
// MSR permission bitmap: read-modify-write over a byte-wide map in one RAM.
// Depends on msrpb_pkg and msrpb_ram.
//
//  channel | direction | handshake            | words
//  in      | input     | in_valid / in_ready  | action, msr_number, access_mask
//  out     | output    | out_valid / out_ready| status, intercepted
//
// Each request does one RAM read, then modify, write-back and result load.
// After reset a clearing pass writes 0xff to every byte, with in_ready low. A held
// result stalls the write-back cycle until out_ready frees the output register; a
// new request can be taken while a result waits.
module msr_permission_bitmap
  import msrpb_pkg::*;
#(
  parameter int MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] msr_number,
  input  logic [1:0]  access_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic        intercepted
);

  localparam int ADDR_W = $clog2(MAP_BYTES);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOKUP} state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_addr;
  logic [1:0]        act;
  logic [1:0]        mask;
  logic              mapped;
  logic [ADDR_W-1:0] addr;
  logic [1:0]        pos;

  logic              dec_hit;
  logic [OFF_W-1:0]  dec_base;
  logic [OFF_W-1:0]  dec_off;
  logic              dec_mapped;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] sel;
  logic [BYTE_W-1:0] byte_next;
  logic              status_next;
  logic              hit_next;
  logic              do_write;
  logic              can_load;

  assign in_ready = (state == S_IDLE);
  assign can_load = !out_valid || out_ready;

  always_comb begin
    dec_hit  = 1'b1;
    dec_base = BASE_LOW;
    priority if (msr_number[31:OFF_W] == PREFIX_LOW) begin
      dec_base = BASE_LOW;
    end else if (msr_number[31:OFF_W] == PREFIX_HIGH) begin
      dec_base = BASE_HIGH;
    end else if (msr_number[31:OFF_W] == PREFIX_EXT) begin
      dec_base = BASE_EXT;
    end else begin
      dec_hit = 1'b0;
    end
    dec_off    = dec_base + {2'b00, msr_number[OFF_W-1:2]};
    dec_mapped = dec_hit && ({1'b0, dec_off} < (OFF_W + 1)'(MAP_BYTES));
  end

  always_comb begin
    sel       = BYTE_W'({mask, 6'b0} >> {~pos, 1'b0});
    byte_next = ram_rdata;
    status_next = 1'b0;
    hit_next    = 1'b0;
    do_write    = 1'b0;
    unique case (act)
      ACT_SET, ACT_CLEAR: begin
        if (mask == 2'b00 || !mapped) begin
          status_next = 1'b1;
        end else begin
          do_write  = 1'b1;
          byte_next = (act == ACT_SET) ? (ram_rdata | sel) : (ram_rdata & ~sel);
        end
      end
      ACT_TEST: begin
        if (mask == 2'b00) begin
          hit_next = 1'b0;
        end else if (!mapped) begin
          hit_next = 1'b1;
        end else begin
          hit_next = |(ram_rdata & sel);
        end
      end
      default: begin
        status_next = 1'b1;
      end
    endcase
  end

  always_comb begin
    ram_raddr = (state == S_IDLE) ? dec_off[ADDR_W-1:0] : addr;
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = byte_next;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = ALL_INTERCEPT;
    end else if (state == S_LOOKUP && can_load && do_write) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(MAP_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            act    <= action;
            mask   <= access_mask;
            mapped <= dec_mapped;
            addr   <= dec_off[ADDR_W-1:0];
            pos    <= msr_number[1:0];
            state  <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (can_load) begin
            status      <= status_next;
            intercepted <= hit_next;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_LOOKUP && can_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  msrpb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAP_BYTES)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

// ===== src/msrpb_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module msrpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== verif/msr_permission_bitmap_checker.sv =====
// Checker for the MSR permission bitmap: watches both channels, keeps its own
// copy of the permission map, predicts every result word and compares it.
// Depends on msrpb_pkg for action codes, byte bases and the reset byte.
module msr_permission_bitmap_checker
  import msrpb_pkg::*;
#(
  parameter int MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] msr_number,
  input  logic [1:0]  access_mask,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        status,
  input  logic        intercepted,
  output int          fail_count,
  output int          pending
);

  localparam logic [31:0] LOW_LAST   = 32'h0000_1fff;
  localparam logic [31:0] HIGH_FIRST = 32'hc000_0000;
  localparam logic [31:0] HIGH_LAST  = 32'hc000_1fff;
  localparam logic [31:0] EXT_FIRST  = 32'hc001_0000;
  localparam logic [31:0] EXT_LAST   = 32'hc001_1fff;

  typedef struct packed {
    logic status;
    logic intercepted;
  } answer_t;

  logic [BYTE_W-1:0] perm_map [MAP_BYTES];
  answer_t expected_answers [$];

  function automatic answer_t map_request(logic [1:0] act, logic [31:0] msr,
                                          logic [1:0] mask);
    answer_t ans;
    logic mapped;
    logic [31:0] base;
    logic [31:0] idx;
    logic [31:0] byte_at;
    logic [2:0] bit_at;
    logic [BYTE_W-1:0] sel;
    ans = '0;
    mapped = 1'b1;
    base = '0;
    idx = '0;
    if (msr <= LOW_LAST) begin
      base = 32'(BASE_LOW);
      idx = msr;
    end else if (msr >= HIGH_FIRST && msr <= HIGH_LAST) begin
      base = 32'(BASE_HIGH);
      idx = msr - HIGH_FIRST;
    end else if (msr >= EXT_FIRST && msr <= EXT_LAST) begin
      base = 32'(BASE_EXT);
      idx = msr - EXT_FIRST;
    end else begin
      mapped = 1'b0;
    end
    byte_at = base + (idx >> 2);
    bit_at = {idx[1:0], 1'b0};
    if (mapped && byte_at >= 32'(MAP_BYTES))
      mapped = 1'b0;
    sel = '0;
    if (mask[0])
      sel[bit_at] = 1'b1;
    if (mask[1])
      sel[bit_at + 3'd1] = 1'b1;
    case (act)
      ACT_SET, ACT_CLEAR: begin
        if (mask == 2'd0 || !mapped) begin
          ans.status = 1'b1;
        end else if (act == ACT_SET) begin
          perm_map[byte_at] = perm_map[byte_at] | sel;
        end else begin
          perm_map[byte_at] = perm_map[byte_at] & ~sel;
        end
      end
      ACT_TEST: begin
        if (mask == 2'd0)
          ans.intercepted = 1'b0;
        else if (!mapped)
          ans.intercepted = 1'b1;
        else
          ans.intercepted = |(perm_map[byte_at] & sel);
      end
      default: ans.status = 1'b1;
    endcase
    return ans;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    answer_t exp_word;
    if (rst) begin
      foreach (perm_map[i])
        perm_map[i] = ALL_INTERCEPT;
      expected_answers.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $error("result word with no request waiting: status %0b intercepted %0b",
                 status, intercepted);
          fail_count++;
        end else begin
          exp_word = expected_answers.pop_front();
          if (status !== exp_word.status) begin
            $error("status: expected %0b, got %0b", exp_word.status, status);
            fail_count++;
          end
          if (intercepted !== exp_word.intercepted) begin
            $error("intercepted: expected %0b, got %0b", exp_word.intercepted,
                   intercepted);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_answers.push_back(map_request(action, msr_number, access_mask));
    end
    pending = expected_answers.size();
  end

endmodule

// ===== verif/msr_permission_bitmap_test.sv =====
// Testbench top for the MSR permission bitmap: clock, reset, request and
// result drivers, directed then random requests, and the verdict.
// Depends on msrpb_pkg, msr_permission_bitmap and msr_permission_bitmap_checker.
module msr_permission_bitmap_test;
  import msrpb_pkg::*;

  localparam logic [1:0] ACT_UNDEFINED = 2'd3;
  localparam int POOL_SIZE = 16;
  localparam int RANDOM_WORDS = 1750;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [31:0] msr_number;
  logic [1:0]  access_mask;
  logic        out_valid;
  logic        out_ready;
  logic        status;
  logic        intercepted;
  int          fail_count;
  int          pending;

  bit          idle_on;
  bit          stall_req;
  logic [31:0] msr_pool [POOL_SIZE];

  msr_permission_bitmap u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .msr_number  (msr_number),
    .access_mask (access_mask),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .intercepted (intercepted)
  );

  msr_permission_bitmap_checker u_intercept_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .msr_number  (msr_number),
    .access_mask (access_mask),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .intercepted (intercepted),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_req) begin
        stall_req = 1'b0;
        hold_left = 200;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < 31);
      end
    end
  end

  task automatic send_word(input logic [1:0] act, input logic [31:0] msr,
                           input logic [1:0] mask);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    msr_number <= msr;
    access_mask <= mask;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  function automatic logic [31:0] mapped_msr();
    case ($urandom_range(2))
      0:       return 32'($urandom_range(32'h1fff));
      1:       return 32'hc000_0000 + 32'($urandom_range(32'h1fff));
      default: return 32'hc001_0000 + 32'($urandom_range(32'h1fff));
    endcase
  endfunction

  function automatic logic [31:0] boundary_msr();
    case ($urandom_range(11))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_1fff;
      2:       return 32'h0000_2000;
      3:       return 32'hbfff_ffff;
      4:       return 32'hc000_0000;
      5:       return 32'hc000_1fff;
      6:       return 32'hc000_2000;
      7:       return 32'hc000_ffff;
      8:       return 32'hc001_0000;
      9:       return 32'hc001_1fff;
      10:      return 32'hc001_2000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [31:0] pick_msr();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50)
      return msr_pool[$urandom_range(POOL_SIZE - 1)];
    if (r < 80)
      return mapped_msr();
    if (r < 90)
      return boundary_msr();
    return $urandom();
  endfunction

  function automatic logic [1:0] pick_action();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3)
      return ACT_UNDEFINED;
    if (r < 33)
      return ACT_SET;
    if (r < 63)
      return ACT_CLEAR;
    return ACT_TEST;
  endfunction

  initial begin
    logic [1:0] mask;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_SET;
    msr_number = '0;
    access_mask = '0;
    idle_on = 1'b1;
    stall_req = 1'b0;
    foreach (msr_pool[i])
      msr_pool[i] = mapped_msr();
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    send_word(ACT_TEST,  32'h0000_0000, 2'd3);
    send_word(ACT_CLEAR, 32'h0000_0000, 2'd1);
    send_word(ACT_TEST,  32'h0000_0000, 2'd1);
    send_word(ACT_TEST,  32'h0000_0000, 2'd2);
    send_word(ACT_CLEAR, 32'h0000_0000, 2'd2);
    send_word(ACT_TEST,  32'h0000_0000, 2'd3);
    send_word(ACT_SET,   32'h0000_0000, 2'd2);
    send_word(ACT_TEST,  32'h0000_0000, 2'd1);
    send_word(ACT_SET,   32'h0000_0001, 2'd0);
    send_word(ACT_CLEAR, 32'h0000_0001, 2'd0);
    send_word(ACT_TEST,  32'h0000_0001, 2'd0);
    send_word(ACT_CLEAR, 32'h0000_2000, 2'd3);
    send_word(ACT_TEST,  32'h0000_2000, 2'd3);
    send_word(ACT_SET,   32'hffff_ffff, 2'd3);
    send_word(ACT_CLEAR, 32'h0000_1fff, 2'd3);
    send_word(ACT_CLEAR, 32'hc000_0000, 2'd3);
    send_word(ACT_CLEAR, 32'hc000_1fff, 2'd3);
    send_word(ACT_CLEAR, 32'hc001_0000, 2'd3);
    send_word(ACT_CLEAR, 32'hc001_1fff, 2'd1);
    send_word(ACT_TEST,  32'h0000_1fff, 2'd3);
    send_word(ACT_TEST,  32'hc000_1fff, 2'd3);
    send_word(ACT_TEST,  32'hc001_1fff, 2'd3);
    send_word(ACT_TEST,  32'hc001_0000, 2'd2);
    send_word(ACT_UNDEFINED, 32'h0000_1fff, 2'd3);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 500)
        stall_req = 1'b1;
      if (n == 700)
        idle_on = 1'b0;
      if (n == 1000)
        idle_on = 1'b1;
      if (n == 1200)
        drain_results();
      if ($urandom_range(49) == 0)
        msr_pool[$urandom_range(POOL_SIZE - 1)] = mapped_msr();
      mask = ($urandom_range(99) < 8) ? 2'd0 : 2'($urandom_range(3, 1));
      send_word(pick_action(), pick_msr(), mask);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
